FILE: sv/rgvc_pkg.sv
`default_nettype none
package rgvc_pkg;

  // Configuration port
  localparam int unsigned CfgIndexW = 4;
  localparam logic [CfgIndexW-1:0] CFG_IDX_OBSTACLE = 4'd0;
  localparam logic [CfgIndexW-1:0] CFG_IDX_TURN_HOLD = 4'd1;
  localparam logic [15:0] OBSTACLE_TICKS_RESET = 16'd60;
  localparam logic [15:0] TURN_HOLD_RESET = 16'd2500;

  // Raw command codes on the input channel
  localparam logic [1:0] CMD_ECHO = 2'd0;
  localparam logic [1:0] CMD_BYTE = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // Tag numbers with a meaning of their own (1-based)
  localparam logic [4:0] TAG_GUIDE_A = 5'd1;
  localparam logic [4:0] TAG_GUIDE_B = 5'd2;
  localparam logic [4:0] TAG_LEFT = 5'd3;
  localparam logic [4:0] TAG_RIGHT = 5'd4;
  localparam logic [4:0] TAG_GUIDE_C = 5'd5;
  localparam logic [4:0] TAG_DEST = 5'd6;
  localparam logic [4:0] TAG_WRONG = 5'd8;
  localparam logic [4:0] TAG_NONE = 5'd0;

  typedef enum logic [1:0] {
    MOTOR_STOP  = 2'd0,
    MOTOR_FWD   = 2'd1,
    MOTOR_LEFT  = 2'd2,
    MOTOR_RIGHT = 2'd3
  } motor_e;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_OBSTACLE = 3'd1,
    EV_DEST     = 3'd2,
    EV_WRONG    = 3'd3,
    EV_MATCH    = 3'd4
  } event_e;

  // Classified request kind; zero bytes and unused commands become KIND_NOP
  typedef enum logic [1:0] {
    KIND_ECHO = 2'd0,
    KIND_BYTE = 2'd1,
    KIND_TICK = 2'd2,
    KIND_NOP  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic       echo_below;
    logic [7:0] rx_byte;
  } item_t;

  // Fixed tag table; characters beyond the text and rows beyond it read as zero
  localparam int unsigned TextChars = 12;
  localparam int unsigned TextTags = 9;
  localparam logic [8*TextChars-1:0] TAG_TEXT [TextTags] = '{
    "150011840383", "1500117AE997", "1500115B3F60",
    "150011566B39", "15001140D195", "150011840282",
    "15001179C0BD", "150011743E4E", "1500117D1F66"
  };

  function automatic logic [7:0] tag_char(input int unsigned t, input int unsigned c);
    logic [7:0] ch;
    ch = 8'h00;
    if (t < TextTags && c < TextChars) begin
      ch = TAG_TEXT[t][8*(TextChars-1-c) +: 8];
    end
    return ch;
  endfunction

endpackage
`default_nettype wire

FILE: sv/rgvc_front.sv
`default_nettype none
module rgvc_front (
  input  wire logic [1:0]    command_i,
  input  wire logic [15:0]   echo_ticks_i,
  input  wire logic [7:0]    rx_byte_i,
  input  wire logic [15:0]   obstacle_ticks_i,
  output rgvc_pkg::item_t    item_o
);

  always_comb begin
    item_o.echo_below = (echo_ticks_i < obstacle_ticks_i);
    item_o.rx_byte    = rx_byte_i;
    unique case (command_i)
      rgvc_pkg::CMD_ECHO: item_o.kind = rgvc_pkg::KIND_ECHO;
      rgvc_pkg::CMD_BYTE: begin
        // drop zero bytes here
        item_o.kind = (rx_byte_i != 8'h00) ? rgvc_pkg::KIND_BYTE : rgvc_pkg::KIND_NOP;
      end
      rgvc_pkg::CMD_TICK: item_o.kind = rgvc_pkg::KIND_TICK;
      default:            item_o.kind = rgvc_pkg::KIND_NOP;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/rgvc_fifo.sv
`default_nettype none
module rgvc_fifo #(
  parameter int unsigned Width = 11,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  input  wire logic [Width-1:0] push_data_i,
  output logic                  push_ready_o,
  output logic                  pop_valid_o,
  output logic [Width-1:0]      pop_data_o,
  input  wire logic             pop_ready_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

FILE: sv/rgvc_back.sv
`default_nettype none
module rgvc_back #(
  parameter int unsigned TAG_CHARS = 12,
  parameter int unsigned NUM_TAGS  = 9
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            item_valid_i,
  input  wire rgvc_pkg::item_t item_i,
  output logic                 item_ready_o,
  input  wire logic [15:0]     turn_hold_ms_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [1:0]           motor_code_o,
  output logic [2:0]           event_code_o,
  output logic [3:0]           tag_index_o
);

  localparam int unsigned PosW = (TAG_CHARS > 1) ? $clog2(TAG_CHARS) : 1;

  logic [7:0]        frame_q [TAG_CHARS];
  logic [PosW-1:0]   count_q, count_d;
  logic              phase_q, phase_d;
  logic              obst_q, obst_d;
  logic [15:0]       timer_q, timer_d;
  rgvc_pkg::motor_e  motor_q, motor_d;
  rgvc_pkg::event_e  event_d;
  logic [4:0]        idx_d;
  logic [4:0]        match_idx;
  logic [7:0]        frame_now [TAG_CHARS];
  logic              out_valid_q;
  logic              take;
  logic              last_char;
  logic              byte_write;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign take         = item_valid_i && item_ready_o;
  assign out_valid_o  = out_valid_q;
  assign last_char    = (count_q == PosW'(TAG_CHARS - 1));
  assign byte_write   = take && (item_i.kind == rgvc_pkg::KIND_BYTE) && (timer_q == 16'd0);

  // Frame as it stands with the incoming byte in place
  always_comb begin
    for (int c = 0; c < TAG_CHARS; c++) begin
      frame_now[c] = (PosW'(c) == count_q) ? item_i.rx_byte : frame_q[c];
    end
  end

  // Lowest matching tag wins
  always_comb begin
    logic same;
    match_idx = rgvc_pkg::TAG_NONE;
    for (int t = NUM_TAGS - 1; t >= 0; t--) begin
      same = 1'b1;
      for (int c = 0; c < TAG_CHARS; c++) begin
        if (frame_now[c] != rgvc_pkg::tag_char(t, c)) begin
          same = 1'b0;
        end
      end
      if (same) begin
        match_idx = 5'(t + 1);
      end
    end
  end

  always_comb begin
    count_d = count_q;
    phase_d = phase_q;
    obst_d  = obst_q;
    timer_d = timer_q;
    motor_d = motor_q;
    event_d = rgvc_pkg::EV_NONE;
    idx_d   = rgvc_pkg::TAG_NONE;
    unique case (item_i.kind)
      rgvc_pkg::KIND_ECHO: begin
        if (!phase_q && timer_q == 16'd0) begin
          if (item_i.echo_below) begin
            if (!obst_q) begin
              motor_d = rgvc_pkg::MOTOR_STOP;
              obst_d  = 1'b1;
              event_d = rgvc_pkg::EV_OBSTACLE;
            end
          end else begin
            motor_d = rgvc_pkg::MOTOR_FWD;
            obst_d  = 1'b0;
          end
        end
      end
      rgvc_pkg::KIND_BYTE: begin
        if (timer_q == 16'd0) begin
          if (last_char) begin
            count_d = '0;
            idx_d   = match_idx;
            if (match_idx != rgvc_pkg::TAG_NONE) begin
              event_d = rgvc_pkg::EV_MATCH;
              if (!phase_q) begin
                if (match_idx == rgvc_pkg::TAG_GUIDE_A || match_idx == rgvc_pkg::TAG_GUIDE_B ||
                    match_idx == rgvc_pkg::TAG_GUIDE_C) begin
                  motor_d = rgvc_pkg::MOTOR_FWD;
                end else if (match_idx == rgvc_pkg::TAG_LEFT ||
                             match_idx == rgvc_pkg::TAG_RIGHT) begin
                  timer_d = turn_hold_ms_i;
                  if (turn_hold_ms_i == 16'd0) begin
                    motor_d = rgvc_pkg::MOTOR_FWD;
                  end else if (match_idx == rgvc_pkg::TAG_LEFT) begin
                    motor_d = rgvc_pkg::MOTOR_LEFT;
                  end else begin
                    motor_d = rgvc_pkg::MOTOR_RIGHT;
                  end
                end else if (match_idx == rgvc_pkg::TAG_DEST) begin
                  motor_d = rgvc_pkg::MOTOR_STOP;
                  phase_d = 1'b1;
                  event_d = rgvc_pkg::EV_DEST;
                end
              end else if (match_idx == rgvc_pkg::TAG_WRONG) begin
                event_d = rgvc_pkg::EV_WRONG;
              end
            end
          end else begin
            count_d = count_q + 1'b1;
          end
        end
      end
      rgvc_pkg::KIND_TICK: begin
        if (timer_q != 16'd0) begin
          timer_d = timer_q - 16'd1;
          if (timer_q == 16'd1) begin
            motor_d = rgvc_pkg::MOTOR_FWD;
          end
        end
      end
      rgvc_pkg::KIND_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      phase_q     <= 1'b0;
      obst_q      <= 1'b0;
      timer_q     <= 16'd0;
      motor_q     <= rgvc_pkg::MOTOR_FWD;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        count_q <= count_d;
        phase_q <= phase_d;
        obst_q  <= obst_d;
        timer_q <= timer_d;
        motor_q <= motor_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_write) begin
      frame_q[count_q] <= item_i.rx_byte;
    end
    if (take) begin
      motor_code_o <= motor_d;
      event_code_o <= event_d;
      tag_index_o  <= idx_d[3:0];
    end
  end

endmodule
`default_nettype wire

FILE: sv/rfid_guided_vehicle_controller_top.sv
`default_nettype none
// Tag-guided vehicle controller. Each request carries a command: an echo
// reading, a reader byte or a millisecond tick; each one returns exactly one
// result with the motor state after the request, an event code and the index
// of a matched tag. The block takes one request per clock cycle while the
// result side is not stalled. The front stage classifies each accepted request
// into a two-entry queue; the back stage, with its state update and nine
// parallel tag compares, pops it and executes it into an output register.
// Either side may stall on its own.
// Configuration writes (index 0 obstacle_ticks, index 1 turn_hold_ms, other
// indexes dropped) are always ready and belong to idle periods; no clearing
// pass runs after reset.
module rfid_guided_vehicle_controller_top #(
  parameter int unsigned TAG_CHARS = 12,
  parameter int unsigned NUM_TAGS  = 9
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // request channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    command_i,
  input  wire logic [15:0]                   echo_ticks_i,
  input  wire logic [7:0]                    rx_byte_i,
  // result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         motor_code_o,
  output logic [2:0]                         event_code_o,
  output logic [3:0]                         tag_index_o,
  // configuration channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rgvc_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [15:0]                   cfg_data_i
);

  logic [15:0]     obstacle_ticks_q;
  logic [15:0]     turn_hold_q;
  rgvc_pkg::item_t front_item;
  rgvc_pkg::item_t queue_item;
  logic            queue_valid;
  logic            back_ready;
  logic            cfg_write;

  // Configuration registers; always accept, drop unknown indexes
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obstacle_ticks_q <= rgvc_pkg::OBSTACLE_TICKS_RESET;
      turn_hold_q      <= rgvc_pkg::TURN_HOLD_RESET;
    end else if (cfg_write) begin
      if (cfg_index_i == rgvc_pkg::CFG_IDX_OBSTACLE) begin
        obstacle_ticks_q <= cfg_data_i;
      end else if (cfg_index_i == rgvc_pkg::CFG_IDX_TURN_HOLD) begin
        turn_hold_q <= cfg_data_i;
      end
    end
  end

  // Front: classify the request (command kind, zero byte, obstacle compare)
  rgvc_front u_front (
    .command_i        (command_i),
    .echo_ticks_i     (echo_ticks_i),
    .rx_byte_i        (rx_byte_i),
    .obstacle_ticks_i (obstacle_ticks_q),
    .item_o           (front_item)
  );

  // Queue between front and back; its free space sets in_ready_o
  rgvc_fifo #(
    .Width ($bits(rgvc_pkg::item_t)),
    .Depth (2)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_data_i  (front_item),
    .push_ready_o (in_ready_o),
    .pop_valid_o  (queue_valid),
    .pop_data_o   (queue_item),
    .pop_ready_i  (back_ready)
  );

  // Back: frame assembly, tag match, motor and phase state, result register
  rgvc_back #(
    .TAG_CHARS (TAG_CHARS),
    .NUM_TAGS  (NUM_TAGS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (queue_valid),
    .item_i         (queue_item),
    .item_ready_o   (back_ready),
    .turn_hold_ms_i (turn_hold_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .motor_code_o   (motor_code_o),
    .event_code_o   (event_code_o),
    .tag_index_o    (tag_index_o)
  );

endmodule
`default_nettype wire

FILE: sv/rgvc_checker.sv
`default_nettype none
module rgvc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [1:0] motor_code_o,
  input wire logic [2:0] event_code_o,
  input wire logic [3:0] tag_index_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(motor_code_o) &&
      $stable(event_code_o) && $stable(tag_index_o))
    else $error("stalled result changed");

  // Destination stops the vehicle
  a_dest_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_code_o == rgvc_pkg::EV_DEST |->
      motor_code_o == rgvc_pkg::MOTOR_STOP)
    else $error("destination without stop");

  // Obstacle stops the vehicle and comes with no tag
  a_obst_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_code_o == rgvc_pkg::EV_OBSTACLE |->
      motor_code_o == rgvc_pkg::MOTOR_STOP && tag_index_o == 4'd0)
    else $error("obstacle result malformed");

  // A reported tag always carries a tag event
  a_tag_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tag_index_o != 4'd0 |->
      event_code_o == rgvc_pkg::EV_MATCH || event_code_o == rgvc_pkg::EV_DEST ||
      event_code_o == rgvc_pkg::EV_WRONG)
    else $error("tag index without tag event");

endmodule

bind rfid_guided_vehicle_controller_top rgvc_checker u_rgvc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .motor_code_o (motor_code_o),
  .event_code_o (event_code_o),
  .tag_index_o  (tag_index_o)
);
`default_nettype wire

FILE: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Frame and tag geometry of the default build.
  localparam int FRAME_LEN = 12;
  localparam int TAG_TOTAL = 9;

  // Command 3 carries no operation; the block only reports its motor state.
  localparam logic [1:0] CMD_NOP = 2'd3;

  // Tags that only ever report a match.
  localparam logic [4:0] TAG_PLAIN_A = 5'd7;
  localparam logic [4:0] TAG_PLAIN_B = 5'd9;

  typedef logic [rgvc_pkg::CfgIndexW-1:0] cfg_index_t;

  // The nine tags the reader can present, first character leftmost.
  localparam logic [8*FRAME_LEN-1:0] KNOWN_TAGS [TAG_TOTAL] = '{
    "150011840383", "1500117AE997", "1500115B3F60",
    "150011566B39", "15001140D195", "150011840282",
    "15001179C0BD", "150011743E4E", "1500117D1F66"
  };

  typedef struct packed {
    rgvc_pkg::motor_e motor;
    rgvc_pkg::event_e ev;
    logic [3:0]       tag;
  } outcome_t;

  localparam outcome_t UNTYPED = '{rgvc_pkg::MOTOR_STOP, rgvc_pkg::EV_NONE, 4'd0};

  // One line of the directed plan: a request, a run of ticks, a whole tag
  // frame, a frame with its last character spoiled, or a register write.
  typedef enum logic [2:0] {
    ROW_ECHO,
    ROW_TICKS,
    ROW_NOP,
    ROW_BYTE,
    ROW_TAG,
    ROW_MISS,
    ROW_SET_OBST,
    ROW_SET_HOLD
  } row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [15:0]      arg;
    logic             typed;
    rgvc_pkg::motor_e motor;
    rgvc_pkg::event_e ev;
    logic [3:0]       tag;
  } plan_row_t;

  // Rows before MOVING_ROWS run in the moving phase; the rest enter the
  // destination phase, which never ends, so they run last.
  localparam int MOVING_ROWS = 28;
  localparam int PLAN_ROWS = 36;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // right after reset: a tick with no turn and an empty command change nothing
    '{ROW_TICKS, 16'd1, 1'b1, rgvc_pkg::MOTOR_FWD, rgvc_pkg::EV_NONE, 4'd0},
    '{ROW_NOP, 16'd0, 1'b1, rgvc_pkg::MOTOR_FWD, rgvc_pkg::EV_NONE, 4'd0},
    // obstacle stops once, repeats stay silent, a reading at the limit is clear
    '{ROW_ECHO, 16'hFFFF, 1'b1, rgvc_pkg::MOTOR_FWD, rgvc_pkg::EV_NONE, 4'd0},
    '{ROW_ECHO, 16'd0, 1'b1, rgvc_pkg::MOTOR_STOP, rgvc_pkg::EV_OBSTACLE, 4'd0},
    '{ROW_ECHO, 16'd0, 1'b1, rgvc_pkg::MOTOR_STOP, rgvc_pkg::EV_NONE, 4'd0},
    '{ROW_ECHO, 16'd60, 1'b1, rgvc_pkg::MOTOR_FWD, rgvc_pkg::EV_NONE, 4'd0},
    // zero byte is dropped, then a guide tag and a spoiled frame
    '{ROW_BYTE, 16'd0, 1'b1, rgvc_pkg::MOTOR_FWD, rgvc_pkg::EV_NONE, 4'd0},
    '{ROW_TAG, 16'(rgvc_pkg::TAG_GUIDE_A), 1'b1,
      rgvc_pkg::MOTOR_FWD, rgvc_pkg::EV_MATCH, 4'(rgvc_pkg::TAG_GUIDE_A)},
    '{ROW_MISS, 16'(rgvc_pkg::TAG_GUIDE_A), 1'b1,
      rgvc_pkg::MOTOR_FWD, rgvc_pkg::EV_NONE, 4'd0},
    // short timed turns; bytes and echoes are dropped while turning
    '{ROW_SET_HOLD, 16'd3, 1'b0, rgvc_pkg::MOTOR_STOP, rgvc_pkg::EV_NONE, 4'd0},
    '{ROW_TAG, 16'(rgvc_pkg::TAG_LEFT), 1'b1,
      rgvc_pkg::MOTOR_LEFT, rgvc_pkg::EV_MATCH, 4'(rgvc_pkg::TAG_LEFT)},
    '{ROW_BYTE, 16'hFF, 1'b1, rgvc_pkg::MOTOR_LEFT, rgvc_pkg::EV_NONE, 4'd0},
    '{ROW_ECHO, 16'd0, 1'b1, rgvc_pkg::MOTOR_LEFT, rgvc_pkg::EV_NONE, 4'd0},
    '{ROW_TICKS, 16'd3, 1'b1, rgvc_pkg::MOTOR_FWD, rgvc_pkg::EV_NONE, 4'd0},
    '{ROW_TAG, 16'(rgvc_pkg::TAG_RIGHT), 1'b1,
      rgvc_pkg::MOTOR_RIGHT, rgvc_pkg::EV_MATCH, 4'(rgvc_pkg::TAG_RIGHT)},
    '{ROW_TICKS, 16'd3, 1'b1, rgvc_pkg::MOTOR_FWD, rgvc_pkg::EV_NONE, 4'd0},
    // zero hold: the turn ends on the spot
    '{ROW_SET_HOLD, 16'd0, 1'b0, rgvc_pkg::MOTOR_STOP, rgvc_pkg::EV_NONE, 4'd0},
    '{ROW_TAG, 16'(rgvc_pkg::TAG_LEFT), 1'b1,
      rgvc_pkg::MOTOR_FWD, rgvc_pkg::EV_MATCH, 4'(rgvc_pkg::TAG_LEFT)},
    '{ROW_TAG, 16'(rgvc_pkg::TAG_GUIDE_B), 1'b1,
      rgvc_pkg::MOTOR_FWD, rgvc_pkg::EV_MATCH, 4'(rgvc_pkg::TAG_GUIDE_B)},
    '{ROW_ECHO, 16'd59, 1'b1, rgvc_pkg::MOTOR_STOP, rgvc_pkg::EV_OBSTACLE, 4'd0},
    '{ROW_TAG, 16'(rgvc_pkg::TAG_GUIDE_C), 1'b1,
      rgvc_pkg::MOTOR_FWD, rgvc_pkg::EV_MATCH, 4'(rgvc_pkg::TAG_GUIDE_C)},
    '{ROW_TAG, 16'(TAG_PLAIN_A), 1'b1,
      rgvc_pkg::MOTOR_FWD, rgvc_pkg::EV_MATCH, 4'(TAG_PLAIN_A)},
    '{ROW_TAG, 16'(TAG_PLAIN_B), 1'b1,
      rgvc_pkg::MOTOR_FWD, rgvc_pkg::EV_MATCH, 4'(TAG_PLAIN_B)},
    // threshold extremes
    '{ROW_SET_OBST, 16'd0, 1'b0, rgvc_pkg::MOTOR_STOP, rgvc_pkg::EV_NONE, 4'd0},
    '{ROW_ECHO, 16'd0, 1'b1, rgvc_pkg::MOTOR_FWD, rgvc_pkg::EV_NONE, 4'd0},
    '{ROW_SET_OBST, 16'hFFFF, 1'b0, rgvc_pkg::MOTOR_STOP, rgvc_pkg::EV_NONE, 4'd0},
    '{ROW_ECHO, 16'hFFFE, 1'b1, rgvc_pkg::MOTOR_STOP, rgvc_pkg::EV_OBSTACLE, 4'd0},
    '{ROW_ECHO, 16'hFFFF, 1'b1, rgvc_pkg::MOTOR_FWD, rgvc_pkg::EV_NONE, 4'd0},
    // destination phase: only the wrong-goods tag raises its own event
    '{ROW_TAG, 16'(rgvc_pkg::TAG_DEST), 1'b1,
      rgvc_pkg::MOTOR_STOP, rgvc_pkg::EV_DEST, 4'(rgvc_pkg::TAG_DEST)},
    '{ROW_TAG, 16'(rgvc_pkg::TAG_WRONG), 1'b1,
      rgvc_pkg::MOTOR_STOP, rgvc_pkg::EV_WRONG, 4'(rgvc_pkg::TAG_WRONG)},
    '{ROW_TAG, 16'(rgvc_pkg::TAG_GUIDE_A), 1'b1,
      rgvc_pkg::MOTOR_STOP, rgvc_pkg::EV_MATCH, 4'(rgvc_pkg::TAG_GUIDE_A)},
    '{ROW_TAG, 16'(rgvc_pkg::TAG_LEFT), 1'b1,
      rgvc_pkg::MOTOR_STOP, rgvc_pkg::EV_MATCH, 4'(rgvc_pkg::TAG_LEFT)},
    '{ROW_TAG, 16'(TAG_PLAIN_B), 1'b1,
      rgvc_pkg::MOTOR_STOP, rgvc_pkg::EV_MATCH, 4'(TAG_PLAIN_B)},
    '{ROW_TAG, 16'(rgvc_pkg::TAG_DEST), 1'b1,
      rgvc_pkg::MOTOR_STOP, rgvc_pkg::EV_MATCH, 4'(rgvc_pkg::TAG_DEST)},
    '{ROW_ECHO, 16'd0, 1'b1, rgvc_pkg::MOTOR_STOP, rgvc_pkg::EV_NONE, 4'd0},
    '{ROW_TICKS, 16'd1, 1'b1, rgvc_pkg::MOTOR_STOP, rgvc_pkg::EV_NONE, 4'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [1:0] command_i;
  logic [15:0] echo_ticks_i;
  logic [7:0] rx_byte_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [1:0] motor_code_o;
  logic [2:0] event_code_o;
  logic [3:0] tag_index_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  cfg_index_t cfg_index_i;
  logic [15:0] cfg_data_i;

  rfid_guided_vehicle_controller_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .echo_ticks_i (echo_ticks_i),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .motor_code_o (motor_code_o),
    .event_code_o (event_code_o),
    .tag_index_o  (tag_index_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Vehicle model kept alongside the block: registers and controller state.
  logic [15:0]      obstacle_limit;
  logic [15:0]      turn_hold;
  logic             at_destination;
  logic             obstacle_latched;
  logic [7:0]       frame_buf [16];
  logic [3:0]       frame_pos;
  logic [15:0]      turn_remaining;
  rgvc_pkg::motor_e motor_now;

  outcome_t pending_outcomes [$];
  int       fault_count = 0;
  bit       jitter_on = 1'b1;
  bit       long_stall_req = 1'b0;
  int       ready_hold = 0;

  function automatic logic [7:0] tag_char_of(input int tag, input int pos);
    return KNOWN_TAGS[tag-1][8*(FRAME_LEN-1-pos) +: 8];
  endfunction

  // Advance the vehicle model by one request and return what the block
  // should report for it.
  function automatic outcome_t vehicle_response(input logic [1:0] cmd,
                                                input logic [15:0] echo,
                                                input logic [7:0] rx);
    outcome_t r;
    int hit, t, c;
    bit same;
    r = '{rgvc_pkg::MOTOR_STOP, rgvc_pkg::EV_NONE, 4'd0};
    case (cmd)
      rgvc_pkg::CMD_ECHO: begin
        if (!at_destination && turn_remaining == 16'd0) begin
          if (echo < obstacle_limit) begin
            if (!obstacle_latched) begin
              motor_now = rgvc_pkg::MOTOR_STOP;
              obstacle_latched = 1'b1;
              r.ev = rgvc_pkg::EV_OBSTACLE;
            end
          end else begin
            motor_now = rgvc_pkg::MOTOR_FWD;
            obstacle_latched = 1'b0;
          end
        end
      end
      rgvc_pkg::CMD_BYTE: begin
        if (rx != 8'h00 && turn_remaining == 16'd0) begin
          frame_buf[frame_pos] = rx;
          if (int'(frame_pos) + 1 >= FRAME_LEN) begin
            frame_pos = 4'd0;
            hit = 0;
            // scan downward so the lowest matching tag wins
            for (t = TAG_TOTAL; t >= 1; t--) begin
              same = 1'b1;
              for (c = 0; c < FRAME_LEN; c++) begin
                if (frame_buf[c] != tag_char_of(t, c)) same = 1'b0;
              end
              if (same) hit = t;
            end
            r.tag = 4'(hit);
            if (hit != 0) begin
              r.ev = rgvc_pkg::EV_MATCH;
              if (!at_destination) begin
                if (hit == rgvc_pkg::TAG_GUIDE_A || hit == rgvc_pkg::TAG_GUIDE_B ||
                    hit == rgvc_pkg::TAG_GUIDE_C) begin
                  motor_now = rgvc_pkg::MOTOR_FWD;
                end else if (hit == rgvc_pkg::TAG_LEFT || hit == rgvc_pkg::TAG_RIGHT) begin
                  turn_remaining = turn_hold;
                  if (turn_hold == 16'd0) motor_now = rgvc_pkg::MOTOR_FWD;
                  else if (hit == rgvc_pkg::TAG_LEFT) motor_now = rgvc_pkg::MOTOR_LEFT;
                  else motor_now = rgvc_pkg::MOTOR_RIGHT;
                end else if (hit == rgvc_pkg::TAG_DEST) begin
                  motor_now = rgvc_pkg::MOTOR_STOP;
                  at_destination = 1'b1;
                  r.ev = rgvc_pkg::EV_DEST;
                end
              end else if (hit == rgvc_pkg::TAG_WRONG) begin
                r.ev = rgvc_pkg::EV_WRONG;
              end
            end
          end else begin
            frame_pos = frame_pos + 4'd1;
          end
        end
      end
      rgvc_pkg::CMD_TICK: begin
        if (turn_remaining != 16'd0) begin
          turn_remaining = turn_remaining - 16'd1;
          if (turn_remaining == 16'd0) motor_now = rgvc_pkg::MOTOR_FWD;
        end
      end
      default: ;
    endcase
    r.motor = motor_now;
    return r;
  endfunction

  // Present one request at the falling edge and hold it until accepted.
  // A typed outcome replaces the model's answer in the expectation queue.
  task automatic offer_request(input logic [1:0] cmd, input logic [15:0] echo,
                               input logic [7:0] rx, input bit typed,
                               input outcome_t want);
    outcome_t pred;
    int gap;
    pred = vehicle_response(cmd, echo, rx);
    @(negedge clk_i);
    gap = 0;
    if (jitter_on && $urandom_range(0, 9) == 0) gap = $urandom_range(1, 7);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    echo_ticks_i <= echo;
    rx_byte_i <= rx;
    pending_outcomes.push_back(typed ? want : pred);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_ticks(input int count, input bit typed, input outcome_t want);
    int i;
    for (i = 0; i < count; i++) begin
      offer_request(rgvc_pkg::CMD_TICK, 16'($urandom), 8'($urandom),
                    typed && i == count - 1, want);
    end
  endtask

  // Feed a tag frame byte by byte; optionally spoil one character and slip
  // dropped zero bytes in between.
  task automatic send_frame(input int tag, input int spoil_at, input logic [7:0] spoil_val,
                            input bit sprinkle, input bit typed, input outcome_t want);
    int c;
    logic [7:0] ch;
    for (c = 0; c < FRAME_LEN; c++) begin
      ch = (c == spoil_at) ? spoil_val : tag_char_of(tag, c);
      if (sprinkle && $urandom_range(0, 19) == 0) begin
        offer_request(rgvc_pkg::CMD_BYTE, 16'($urandom), 8'h00, 1'b0, UNTYPED);
      end
      offer_request(rgvc_pkg::CMD_BYTE, 16'($urandom), ch, typed && c == FRAME_LEN - 1, want);
    end
  endtask

  // Bring the reader back to a frame boundary: finish a running turn (unless
  // the caller lets a frame land inside it) and pad a partial frame.
  task automatic line_up_frame(input bit always_finish);
    if (turn_remaining != 16'd0 && (always_finish || $urandom_range(0, 4) != 0)) begin
      send_ticks(int'(turn_remaining), 1'b0, UNTYPED);
    end
    if (turn_remaining == 16'd0) begin
      while (frame_pos != 4'd0) begin
        offer_request(rgvc_pkg::CMD_BYTE, 16'($urandom), 8'($urandom_range(1, 255)),
                      1'b0, UNTYPED);
      end
    end
  endtask

  // Drop valid and hold until every expected result has been taken.
  task automatic wait_for_results();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_index_t idx, input logic [15:0] val);
    wait_for_results();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == rgvc_pkg::CFG_IDX_OBSTACLE) obstacle_limit = val;
    else if (idx == rgvc_pkg::CFG_IDX_TURN_HOLD) turn_hold = val;
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  task automatic walk_plan(input int first, input int last);
    int i;
    plan_row_t row;
    outcome_t want;
    for (i = first; i < last; i++) begin
      row = PLAN[i];
      want = '{row.motor, row.ev, row.tag};
      case (row.kind)
        ROW_ECHO: offer_request(rgvc_pkg::CMD_ECHO, row.arg, 8'($urandom), row.typed, want);
        ROW_TICKS: send_ticks(int'(row.arg), row.typed, want);
        ROW_NOP: offer_request(CMD_NOP, 16'($urandom), 8'($urandom), row.typed, want);
        ROW_BYTE: offer_request(rgvc_pkg::CMD_BYTE, 16'($urandom), row.arg[7:0],
                                row.typed, want);
        ROW_TAG: send_frame(int'(row.arg), -1, 8'h00, 1'b0, row.typed, want);
        ROW_MISS: send_frame(int'(row.arg), FRAME_LEN - 1, 8'hFF, 1'b0, row.typed, want);
        ROW_SET_OBST: write_register(rgvc_pkg::CFG_IDX_OBSTACLE, row.arg);
        ROW_SET_HOLD: write_register(rgvc_pkg::CFG_IDX_TURN_HOLD, row.arg);
        default: ;
      endcase
    end
  endtask

  // Random traffic: mostly clean frames with random tags, plus echo readings
  // around the threshold, tick bursts, stray bytes and empty commands.
  // Dropped zero bytes do not count toward the amount.
  task automatic roam(input int amount, input bit allow_dest);
    int sent, pick, tag, spoil_at, val;
    sent = 0;
    while (sent < amount) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        line_up_frame(1'b0);
        tag = $urandom_range(1, TAG_TOTAL);
        // keep the moving phase alive: the destination tag is final
        if (!allow_dest && tag == rgvc_pkg::TAG_DEST) tag = $urandom_range(1, 5);
        spoil_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, FRAME_LEN - 1) : -1;
        send_frame(tag, spoil_at, 8'($urandom_range(1, 255)), 1'b1, 1'b0, UNTYPED);
        sent += FRAME_LEN;
      end else if (pick < 65) begin
        case ($urandom_range(0, 3))
          0, 1: val = int'(obstacle_limit) + int'($urandom_range(0, 4)) - 2;
          2: val = $urandom_range(0, 65535);
          default: val = ($urandom_range(0, 1) == 1) ? 65535 : 0;
        endcase
        if (val < 0) val = 0;
        if (val > 65535) val = 65535;
        offer_request(rgvc_pkg::CMD_ECHO, 16'(val), 8'($urandom), 1'b0, UNTYPED);
        sent++;
      end else if (pick < 80) begin
        val = $urandom_range(1, 4);
        send_ticks(val, 1'b0, UNTYPED);
        sent += val;
      end else if (pick < 88) begin
        // stray byte: knocks the frame out of step until padded again
        offer_request(rgvc_pkg::CMD_BYTE, 16'($urandom), 8'($urandom_range(1, 255)),
                      1'b0, UNTYPED);
        sent++;
      end else if (pick < 93) begin
        offer_request(CMD_NOP, 16'($urandom), 8'($urandom), 1'b0, UNTYPED);
        sent++;
      end else begin
        offer_request(rgvc_pkg::CMD_BYTE, 16'($urandom), 8'h00, 1'b0, UNTYPED);
      end
    end
  endtask

  // Compare every result taken from the block with the oldest expectation.
  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outcomes.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("unexpected result: motor %0d event %0d tag %0d",
                   motor_code_o, event_code_o, tag_index_o);
        end
      end else begin
        want = pending_outcomes.pop_front();
        if (motor_code_o !== want.motor || event_code_o !== want.ev ||
            tag_index_o !== want.tag) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("result mismatch: motor %0d/%0d event %0d/%0d tag %0d/%0d (exp/got)",
                     want.motor, motor_code_o, want.ev, event_code_o,
                     want.tag, tag_index_o);
          end
        end
      end
    end
  end

  // Result side: random back-pressure bursts, plus one long hold on request so
  // the block fills up and stalls its input.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        ready_hold = 60;
      end
      if (ready_hold != 0) begin
        ready_hold--;
        out_ready_i <= 1'b0;
      end else if (jitter_on && $urandom_range(0, 11) == 0) begin
        ready_hold = $urandom_range(0, 6);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = rgvc_pkg::CMD_ECHO;
    echo_ticks_i = 16'd0;
    rx_byte_i = 8'd0;
    cfg_valid_i = 1'b0;
    cfg_index_i = rgvc_pkg::CFG_IDX_OBSTACLE;
    cfg_data_i = 16'd0;
    obstacle_limit = rgvc_pkg::OBSTACLE_TICKS_RESET;
    turn_hold = rgvc_pkg::TURN_HOLD_RESET;
    at_destination = 1'b0;
    obstacle_latched = 1'b0;
    frame_pos = 4'd0;
    turn_remaining = 16'd0;
    motor_now = rgvc_pkg::MOTOR_FWD;
    foreach (frame_buf[i]) frame_buf[i] = 8'h00;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed moving-phase cases, starting from the reset registers.
    walk_plan(0, MOVING_ROWS);

    // Random moving phase over several register settings; each write first
    // waits for every outstanding result.
    write_register(rgvc_pkg::CFG_IDX_OBSTACLE, 16'($urandom_range(20, 120)));
    write_register(rgvc_pkg::CFG_IDX_TURN_HOLD, 16'($urandom_range(1, 12)));
    roam(220, 1'b0);

    write_register(rgvc_pkg::CFG_IDX_OBSTACLE, 16'd0);
    write_register(rgvc_pkg::CFG_IDX_TURN_HOLD, 16'd0);
    roam(70, 1'b0);
    // stall the result side for a long stretch while requests keep coming
    long_stall_req = 1'b1;
    roam(110, 1'b0);

    // Unused indexes must be dropped; run a stretch without idling.
    write_register(rgvc_pkg::CFG_IDX_OBSTACLE, 16'hFFFF);
    write_register(rgvc_pkg::CFG_IDX_TURN_HOLD, 16'($urandom_range(1, 5)));
    write_register('1, 16'($urandom));
    write_register(cfg_index_t'($urandom_range(2, 14)), 16'hFFFF);
    jitter_on = 1'b0;
    roam(150, 1'b0);
    jitter_on = 1'b1;

    write_register(rgvc_pkg::CFG_IDX_OBSTACLE, 16'($urandom));
    write_register(rgvc_pkg::CFG_IDX_TURN_HOLD, 16'($urandom_range(0, 30)));
    roam(180, 1'b0);

    // Long turn: hold it through every tick without idling.
    write_register(rgvc_pkg::CFG_IDX_TURN_HOLD, 16'd40);
    jitter_on = 1'b0;
    line_up_frame(1'b1);
    send_frame(rgvc_pkg::TAG_RIGHT, -1, 8'h00, 1'b0, 1'b0, UNTYPED);
    send_ticks(40, 1'b0, UNTYPED);
    jitter_on = 1'b1;

    // Directed destination cases, then random traffic in that phase.
    write_register(rgvc_pkg::CFG_IDX_TURN_HOLD, 16'($urandom_range(1, 8)));
    write_register(rgvc_pkg::CFG_IDX_OBSTACLE, 16'($urandom_range(30, 90)));
    line_up_frame(1'b1);
    walk_plan(MOVING_ROWS, PLAN_ROWS);
    roam(180, 1'b1);

    // Closing stretch with no idling on either side.
    jitter_on = 1'b0;
    roam(80, 1'b1);

    wait_for_results();
    repeat (8) @(posedge clk_i);
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
